FILE: rtl/core/deflate_fixed_huffman_token_encoder_top_defines.svh
// assertion macros for the deflate fixed huffman token encoder
// used by the top level, expects i_clk and i_rst_n in scope
`ifndef DEFLATE_FIXED_HUFFMAN_TOKEN_ENCODER_TOP_DEFINES_SVH
`define DEFLATE_FIXED_HUFFMAN_TOKEN_ENCODER_TOP_DEFINES_SVH

// condition holds in the same cycle
`define DFHTE_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// condition holds in the next cycle
`define DFHTE_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: rtl/core/dfhte_pkg.sv
// types and constants of the deflate fixed huffman token encoder
// no dependencies
package dfhte_pkg;

    localparam logic [1:0] ACT_LITERAL = 2'd0;
    localparam logic [1:0] ACT_PAIR    = 2'd1;
    localparam logic [1:0] ACT_EOB     = 2'd2;

    localparam logic [1:0] KIND_LIT  = 2'd0;
    localparam logic [1:0] KIND_PAIR = 2'd1;
    localparam logic [1:0] KIND_EOB  = 2'd2;
    localparam logic [1:0] KIND_BAD  = 2'd3;

    localparam logic [8:0] SYM_EOB      = 9'd256;
    localparam logic [8:0] SYM_LEN_BASE = 9'd257;
    localparam logic [8:0] SYM_LEN_MAX  = 9'd285;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  literal_byte;
        logic [8:0]  match_length;
        logic [15:0] match_distance;
    } t_in;

    typedef struct packed {
        logic [8:0]  lit_len_symbol;
        logic [8:0]  huff_code;
        logic [3:0]  huff_bits;
        logic [2:0]  length_extra_bits;
        logic [4:0]  length_extra_value;
        logic        has_distance;
        logic [4:0]  distance_code;
        logic [3:0]  distance_extra_bits;
        logic [12:0] distance_extra_value;
        logic        invalid;
    } t_out;

    // classified token as it waits in the queue
    typedef struct packed {
        logic [1:0]  kind;
        logic [8:0]  sym;
        logic [2:0]  lxb;
        logic [4:0]  lxv;
        logic [4:0]  dsym;
        logic [3:0]  dxb;
        logic [12:0] dxv;
    } t_cls;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

FILE: rtl/core/deflate_fixed_huffman_token_encoder_top.sv
// Deflate fixed-Huffman token encoder: maps literal, length/distance and
// end-of-block tokens to RFC 1951 fixed codes. Sustains one token per cycle
// while the output is ready. A token is classified and written into the queue,
// then its code is looked up into the output register. The queue of QUEUE_DEPTH
// entries lets the input side keep accepting while the output is stalled, until full.
// depends on dfhte_pkg, dfhte_front, dfhte_queue, dfhte_back and the defines header
`include "deflate_fixed_huffman_token_encoder_top_defines.svh"
module deflate_fixed_huffman_token_encoder_top
    import dfhte_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    t_cls    front_cls;
    t_cls    head_cls;
    t_q_stat q_stat;
    logic    pop;

    dfhte_front u_front (
        .i_token (i_data),
        .o_cls   (front_cls)
    );

    dfhte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_data  (front_cls),
        .i_pop   (pop),
        .o_data  (head_cls),
        .o_stat  (q_stat)
    );

    dfhte_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (!q_stat.empty),
        .i_cls      (head_cls),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );

    assign o_ready = !q_stat.full;

    `DFHTE_ASSERT_NEXT(a_drain, !q_stat.empty && (!o_valid || i_ready), o_valid, "queued beat not moved to output")
    `DFHTE_ASSERT_NOW(a_bad_empty, o_valid && o_data.invalid, o_data.huff_bits == 4'd0 && !o_data.has_distance, "invalid beat carries a code")
    `DFHTE_ASSERT_NOW(a_pair_sym, o_valid && o_data.has_distance, o_data.lit_len_symbol >= SYM_LEN_BASE && o_data.lit_len_symbol <= SYM_LEN_MAX, "pair beat without length symbol")
    `DFHTE_ASSERT_NOW(a_bits_range, o_valid && !o_data.invalid, o_data.huff_bits >= 4'd7 && o_data.huff_bits <= 4'd9, "code length out of range")

endmodule

FILE: rtl/core/dfhte_front.sv
// front end: range checks and length/distance symbol decoding
// depends on dfhte_pkg
module dfhte_front
    import dfhte_pkg::*;
(
    input  t_in  i_token,
    output t_cls o_cls
);

    logic        len_ok;
    logic        dist_ok;
    logic [7:0]  len_i;
    logic [2:0]  len_b;
    logic [8:0]  len_sym;
    logic [4:0]  len_xv;
    logic [2:0]  len_xb;
    logic [14:0] dist_i;
    logic [3:0]  dist_b;
    logic [4:0]  dist_sym;
    logic [12:0] dist_xv;
    logic [3:0]  dist_xb;

    assign len_ok  = (i_token.match_length >= 9'd3) && (i_token.match_length <= 9'd258);
    assign dist_ok = (i_token.match_distance >= 16'd1) &&
                     (i_token.match_distance <= 16'd32768);

    // length symbol, extra bits = msb position of (len - 3) minus 2
    always_comb begin
        len_i   = 8'(i_token.match_length - 9'd3);
        len_b   = 3'd1;
        len_sym = 9'(i_token.match_length + 9'd254);
        len_xv  = 5'd0;
        len_xb  = 3'd0;
        if (len_i[7]) begin
            len_b = 3'd5;
        end else if (len_i[6]) begin
            len_b = 3'd4;
        end else if (len_i[5]) begin
            len_b = 3'd3;
        end else if (len_i[4]) begin
            len_b = 3'd2;
        end
        if (i_token.match_length == 9'd258) begin
            len_sym = SYM_LEN_MAX;
        end else if (i_token.match_length > 9'd10) begin
            len_xb  = len_b;
            len_sym = SYM_LEN_BASE + {4'd0, len_b, 2'b00} + 9'(len_i >> len_b);
            len_xv  = 5'(len_i & ((8'd1 << len_b) - 8'd1));
        end
    end

    // distance symbol, extra bits = msb position of (dist - 1) minus 1
    always_comb begin
        dist_i   = 15'(i_token.match_distance - 16'd1);
        dist_b   = 4'd1;
        dist_sym = 5'(dist_i);
        dist_xv  = 13'd0;
        dist_xb  = 4'd0;
        for (int k = 2; k < 15; k++) begin
            if (dist_i[k]) begin
                dist_b = 4'(k - 1);
            end
        end
        if (i_token.match_distance > 16'd4) begin
            dist_xb  = dist_b;
            dist_sym = {dist_b, 1'b0} + 5'(dist_i >> dist_b);
            dist_xv  = 13'(dist_i & ((15'd1 << dist_b) - 15'd1));
        end
    end

    always_comb begin
        o_cls = '0;
        case (i_token.action)
            ACT_LITERAL: begin
                o_cls.kind = KIND_LIT;
                o_cls.sym  = {1'b0, i_token.literal_byte};
            end
            ACT_EOB: begin
                o_cls.kind = KIND_EOB;
                o_cls.sym  = SYM_EOB;
            end
            ACT_PAIR: begin
                if (len_ok && dist_ok) begin
                    o_cls.kind = KIND_PAIR;
                    o_cls.sym  = len_sym;
                    o_cls.lxb  = len_xb;
                    o_cls.lxv  = len_xv;
                    o_cls.dsym = dist_sym;
                    o_cls.dxb  = dist_xb;
                    o_cls.dxv  = dist_xv;
                end else begin
                    o_cls.kind = KIND_BAD;
                end
            end
            default: begin
                o_cls.kind = KIND_BAD;
            end
        endcase
    end

endmodule

FILE: rtl/core/dfhte_queue.sv
// short fifo between front end and back end
// depends on dfhte_pkg
module dfhte_queue
    import dfhte_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cls    i_data,
    input  logic    i_pop,
    output t_cls    o_data,
    output t_q_stat o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cls            r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   n_wr_ptr;
    logic [AW-1:0]   n_rd_ptr;
    logic [CW-1:0]   n_count;
    logic            do_push;
    logic            do_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: rtl/core/dfhte_back.sv
// back end: fixed huffman code lookup and output register
// depends on dfhte_pkg
module dfhte_back
    import dfhte_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_cls i_cls,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    logic r_valid;
    t_out r_data;
    t_out n_data;
    logic take;

    assign take    = i_in_valid && (!r_valid || i_ready);
    assign o_pop   = take;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data = '0;
        if (i_cls.kind == KIND_BAD) begin
            n_data.invalid = 1'b1;
        end else begin
            n_data.lit_len_symbol = i_cls.sym;
            if (i_cls.sym <= 9'd143) begin
                n_data.huff_bits = 4'd8;
                n_data.huff_code = i_cls.sym + 9'h030;
            end else if (i_cls.sym <= 9'd255) begin
                n_data.huff_bits = 4'd9;
                n_data.huff_code = i_cls.sym + 9'd256;
            end else if (i_cls.sym <= 9'd279) begin
                n_data.huff_bits = 4'd7;
                n_data.huff_code = i_cls.sym - 9'd256;
            end else begin
                n_data.huff_bits = 4'd8;
                n_data.huff_code = i_cls.sym - 9'd88;
            end
            if (i_cls.kind == KIND_PAIR) begin
                n_data.length_extra_bits    = i_cls.lxb;
                n_data.length_extra_value   = i_cls.lxv;
                n_data.has_distance         = 1'b1;
                n_data.distance_code        = i_cls.dsym;
                n_data.distance_extra_bits  = i_cls.dxb;
                n_data.distance_extra_value = i_cls.dxv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= take || (r_valid && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_data <= n_data;
        end
    end

endmodule

FILE: verif/deflate_fixed_huffman_token_encoder_top_tb.sv
// testbench for deflate_fixed_huffman_token_encoder_top: drives literal, match and
// end-of-block tokens and checks every code beat against a built-in encoder model
// depends on dfhte_pkg and the rtl of the encoder
module deflate_fixed_huffman_token_encoder_top_tb;
    import dfhte_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int unsigned MIN_LENGTH = 3;
    localparam int unsigned MAX_LENGTH = 258;
    localparam int unsigned MAX_DISTANCE = 32768;
    localparam int STALL_LIMIT = 5000;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int DRAIN_TAIL = 20;
    localparam int REPORT_LIMIT = 10;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_in  i_data = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_out o_data;

    t_out pending_codes[$];
    int   fault_count = 0;
    int   quiet_cycles = 0;
    int   tx_idle_pct = 14;
    int   rx_idle_pct = 14;
    bit   rx_hold_req = 1'b0;

    deflate_fixed_huffman_token_encoder_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- encoder model

    function automatic int unsigned top_bit(input int unsigned v);
        int unsigned p;
        p = 0;
        while (v > 1) begin
            v = v >> 1;
            p++;
        end
        return p;
    endfunction

    function automatic t_out encode_token(input t_in tok);
        t_out        r;
        int unsigned sym;
        int unsigned len;
        int unsigned distance;
        int unsigned idx;
        int unsigned nb;
        r        = '0;
        len      = tok.match_length;
        distance = tok.match_distance;
        if (tok.action == ACT_LITERAL) begin
            sym = tok.literal_byte;
        end else if (tok.action == ACT_EOB) begin
            sym = SYM_EOB;
        end else if (tok.action == ACT_PAIR && len >= MIN_LENGTH && len <= MAX_LENGTH &&
                     distance >= 1 && distance <= MAX_DISTANCE) begin
            if (len <= 10) begin
                sym = SYM_LEN_BASE + len - MIN_LENGTH;
            end else if (len == MAX_LENGTH) begin
                sym = SYM_LEN_MAX;
            end else begin
                idx = len - MIN_LENGTH;
                nb  = top_bit(idx) - 2;
                sym = SYM_LEN_BASE + 4 * nb + (idx >> nb);
                r.length_extra_bits  = 3'(nb);
                r.length_extra_value = 5'(idx & ((1 << nb) - 1));
            end
            // distance: first four codes carry no extra bits
            if (distance <= 4) begin
                r.distance_code = 5'(distance - 1);
            end else begin
                idx = distance - 1;
                nb  = top_bit(idx) - 1;
                r.distance_code        = 5'(2 * nb + (idx >> nb));
                r.distance_extra_bits  = 4'(nb);
                r.distance_extra_value = 13'(idx & ((1 << nb) - 1));
            end
            r.has_distance = 1'b1;
        end else begin
            r.invalid = 1'b1;
            return r;
        end
        r.lit_len_symbol = 9'(sym);
        if (sym <= 143) begin
            r.huff_bits = 4'd8;
            r.huff_code = 9'(sym + 'h030);
        end else if (sym <= 255) begin
            r.huff_bits = 4'd9;
            r.huff_code = 9'(sym - 144 + 'h190);
        end else if (sym <= 279) begin
            r.huff_bits = 4'd7;
            r.huff_code = 9'(sym - 256);
        end else begin
            r.huff_bits = 4'd8;
            r.huff_code = 9'(sym - 280 + 'h0c0);
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- result checking

    function automatic string fmt_code(input t_out r);
        return $sformatf("sym=%0d code=%h bits=%0d lx=%0d/%0d hd=%0d dc=%0d dx=%0d/%0d inv=%0d",
                         r.lit_len_symbol, r.huff_code, r.huff_bits, r.length_extra_bits,
                         r.length_extra_value, r.has_distance, r.distance_code,
                         r.distance_extra_bits, r.distance_extra_value, r.invalid);
    endfunction

    function automatic string diff_fields(input t_out want, input t_out got);
        string s;
        s = "";
        if (got.lit_len_symbol !== want.lit_len_symbol) s = {s, " lit_len_symbol"};
        if (got.huff_code !== want.huff_code) s = {s, " huff_code"};
        if (got.huff_bits !== want.huff_bits) s = {s, " huff_bits"};
        if (got.length_extra_bits !== want.length_extra_bits) s = {s, " length_extra_bits"};
        if (got.length_extra_value !== want.length_extra_value) s = {s, " length_extra_value"};
        if (got.has_distance !== want.has_distance) s = {s, " has_distance"};
        if (got.distance_code !== want.distance_code) s = {s, " distance_code"};
        if (got.distance_extra_bits !== want.distance_extra_bits) s = {s, " distance_extra_bits"};
        if (got.distance_extra_value !== want.distance_extra_value)
            s = {s, " distance_extra_value"};
        if (got.invalid !== want.invalid) s = {s, " invalid"};
        return s;
    endfunction

    task automatic report_fault(input string msg);
        fault_count++;
        if (fault_count <= REPORT_LIMIT) begin
            $display("error: %s", msg);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_out  want;
        string diffs;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                pending_codes.insert(pending_codes.size(), encode_token(i_data));
            end
            if (o_valid && i_ready) begin
                if (pending_codes.size() == 0) begin
                    report_fault($sformatf("unexpected beat: %s", fmt_code(o_data)));
                end else begin
                    want  = pending_codes.pop_front();
                    diffs = diff_fields(want, o_data);
                    if (diffs != "") begin
                        report_fault($sformatf("mismatch in%s\n  exp %s\n  got %s",
                                               diffs, fmt_code(want), fmt_code(o_data)));
                    end
                end
            end
        end
    end

    // no beat moving on either side for too long means the block hung
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- result side

    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                i_ready <= 1'b0;
                for (int n = 0; n < RX_HOLD_CYCLES; n++) begin
                    @(posedge i_clk);
                end
                rx_hold_req = 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // ---------------------------------------------------------------- token side

    function automatic t_in make_token(input logic [1:0] action, input int unsigned lit,
                                       input int unsigned len, input int unsigned dist_in);
        t_in tok;
        tok.action         = action;
        tok.literal_byte   = 8'(lit);
        tok.match_length   = 9'(len);
        tok.match_distance = 16'(dist_in);
        return tok;
    endfunction

    function automatic t_in random_token();
        t_in         tok;
        int unsigned pick;
        int unsigned nb;
        tok.action         = 2'($urandom);
        tok.literal_byte   = 8'($urandom);
        tok.match_length   = 9'($urandom);
        tok.match_distance = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 45) begin
            tok.action = ACT_LITERAL;
        end else if (pick < 85) begin
            tok.action       = ACT_PAIR;
            tok.match_length = 9'($urandom_range(MAX_LENGTH, MIN_LENGTH));
            // spread distances evenly over the code ranges
            nb = $urandom_range(15);
            if (nb == 15) begin
                tok.match_distance = 16'(MAX_DISTANCE);
            end else begin
                tok.match_distance = 16'((1 << nb) | ($urandom & ((1 << nb) - 1)));
            end
        end else if (pick < 90) begin
            tok.action = ACT_EOB;
        end else begin
            case ($urandom_range(3))
                0: tok.action = ACT_UNUSED;
                1: begin
                    tok.action = ACT_PAIR;
                    if ($urandom_range(1)) begin
                        tok.match_length = 9'($urandom_range(MIN_LENGTH - 1, 0));
                    end else begin
                        tok.match_length = 9'($urandom_range(511, MAX_LENGTH + 1));
                    end
                end
                2: begin
                    tok.action       = ACT_PAIR;
                    tok.match_length = 9'($urandom_range(MAX_LENGTH, MIN_LENGTH));
                    if ($urandom_range(1)) begin
                        tok.match_distance = '0;
                    end else begin
                        tok.match_distance = 16'($urandom_range(65535, MAX_DISTANCE + 1));
                    end
                end
                default: ;  // fully random token
            endcase
        end
        return tok;
    endfunction

    // valid is only dropped in a gap, so back-to-back beats keep it high
    task automatic send_token(input t_in tok);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= tok;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
    endtask

    // an edge always passes before the check, so the last accepted beat is already queued
    task automatic wait_codes_drained();
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_codes.size() != 0);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_code_boundaries();
        send_token(make_token(ACT_LITERAL, 0, 0, 0));
        send_token(make_token(ACT_LITERAL, 143, 511, 65535));
        send_token(make_token(ACT_LITERAL, 144, 0, 0));
        send_token(make_token(ACT_LITERAL, 255, 511, 65535));
        send_token(make_token(ACT_EOB, 0, 0, 0));
        send_token(make_token(ACT_EOB, 255, 511, 65535));
        send_token(make_token(ACT_PAIR, 0, 3, 1));
        send_token(make_token(ACT_PAIR, 255, 10, 4));
        send_token(make_token(ACT_PAIR, 0, 11, 5));
        send_token(make_token(ACT_PAIR, 0, 114, 24576));
        send_token(make_token(ACT_PAIR, 0, 115, 24577));
        send_token(make_token(ACT_PAIR, 0, 257, 32768));
        send_token(make_token(ACT_PAIR, 0, 258, 32768));
        // out of range length or distance
        send_token(make_token(ACT_PAIR, 0, 2, 1));
        send_token(make_token(ACT_PAIR, 0, 259, 1));
        send_token(make_token(ACT_PAIR, 0, 511, 100));
        send_token(make_token(ACT_PAIR, 0, 3, 0));
        send_token(make_token(ACT_PAIR, 0, 258, 32769));
        send_token(make_token(ACT_PAIR, 0, 0, 65535));
        // undefined token kind
        send_token(make_token(ACT_UNUSED, 0, 3, 1));
        send_token(make_token(ACT_UNUSED, 255, 511, 65535));
        wait_codes_drained();
    endtask

    task automatic test_output_backpressure();
        rx_hold_req = 1'b1;
        for (int n = 0; n < 40; n++) begin
            send_token(random_token());
        end
        wait_codes_drained();
    endtask

    task automatic test_full_rate_stream();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int n = 0; n < 300; n++) begin
            send_token(random_token());
        end
        tx_idle_pct = 14;
        rx_idle_pct = 14;
        wait_codes_drained();
    endtask

    task automatic test_random_tokens();
        for (int n = 0; n < 1100; n++) begin
            send_token(random_token());
        end
        wait_codes_drained();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_code_boundaries();
        test_output_backpressure();
        test_random_tokens();
        test_full_rate_stream();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (fault_count == 0 && pending_codes.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/dfhte_pkg.sv
rtl/core/dfhte_front.sv
rtl/core/dfhte_queue.sv
rtl/core/dfhte_back.sv
rtl/core/deflate_fixed_huffman_token_encoder_top.sv
verif/deflate_fixed_huffman_token_encoder_top_tb.sv
